FILE: hw/rtl/sfcs_pkg.sv
// shared types and constants of the spi flash command sequencer
`default_nettype none
package sfcs_pkg;

	localparam int PAGE_BYTES_DEF   = 256;
	localparam int ADDRESS_BITS_DEF = 24;
	localparam int QUEUE_DEPTH      = 4;

	// request codes
	localparam logic [3:0] CMD_READ   = 4'd0;
	localparam logic [3:0] CMD_PSTART = 4'd1;
	localparam logic [3:0] CMD_PDATA  = 4'd2;
	localparam logic [3:0] CMD_SERASE = 4'd3;
	localparam logic [3:0] CMD_BERASE = 4'd4;
	localparam logic [3:0] CMD_CERASE = 4'd5;
	localparam logic [3:0] CMD_WRSR   = 4'd6;
	localparam logic [3:0] CMD_RDSR   = 4'd7;
	localparam logic [3:0] CMD_REPLY  = 4'd8;

	// result kinds
	localparam logic [1:0] KIND_SPI    = 2'd0;
	localparam logic [1:0] KIND_HOST   = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_REFUSE = 2'd3;

	// flash opcodes
	localparam logic [7:0] OP_WREN   = 8'h06;
	localparam logic [7:0] OP_RDSR   = 8'h05;
	localparam logic [7:0] OP_WRSR   = 8'h01;
	localparam logic [7:0] OP_READ   = 8'h03;
	localparam logic [7:0] OP_PP     = 8'h02;
	localparam logic [7:0] OP_SE     = 8'h20;
	localparam logic [7:0] OP_BE     = 8'hD8;
	localparam logic [7:0] OP_CE     = 8'hC7;
	localparam logic [7:0] DUMMY     = 8'hFF;

	// closing part of a transaction sequence
	localparam logic [2:0] TAIL_NONE   = 3'd0;
	localparam logic [2:0] TAIL_DONE   = 3'd1;
	localparam logic [2:0] TAIL_REFUSE = 3'd2;
	localparam logic [2:0] TAIL_DUMMY  = 3'd3;
	localparam logic [2:0] TAIL_POLL   = 3'd4;

	typedef struct packed {
		logic        host_en;
		logic        wren_en;
		logic        op_en;
		logic [7:0]  op_val;
		logic        op_rel;
		logic        addr_en;
		logic [23:0] addr;
		logic        addr_rel;
		logic        byte_en;
		logic        byte_rel;
		logic [7:0]  dat;
		logic [2:0]  tail;
		logic        dummy_rel;
	} desc_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sfcs_front.sv
// request decoder: tracks flash state and emits sequence descriptors
`default_nettype none
module sfcs_front #(
	parameter int PAGE_BYTES   = sfcs_pkg::PAGE_BYTES_DEF,
	parameter int ADDRESS_BITS = sfcs_pkg::ADDRESS_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire logic [3:0]    command,
	input  wire logic [23:0]   flash_address,
	input  wire logic [24:0]   byte_count,
	input  wire logic [7:0]    data_byte,
	input  wire logic          q_full,
	output logic               push,
	output sfcs_pkg::desc_t    push_desc
);

	localparam int ADDR_W = (ADDRESS_BITS < 24) ? ADDRESS_BITS : 24;
	localparam int OFF_W  = $clog2(PAGE_BYTES);
	localparam int PROD_W = 2 * ADDR_W + 1;
	localparam logic [63:0] RECIP =
		((64'd1 << (ADDR_W + OFF_W)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_READ = 3'd1;
	localparam logic [2:0] M_PROG = 3'd2;
	localparam logic [2:0] M_WAIT = 3'd3;
	localparam logic [2:0] M_STAT = 3'd4;

	logic [2:0]        mode_q, mode_n;
	logic [ADDR_W-1:0] cur_q, cur_n;
	logic [24:0]       bl_q, bl_n, bl_dec;
	logic              poll_q, poll_n;
	logic              resume_q, resume_n;
	logic [OFF_W-1:0]  off_q, off_n;
	logic              rem_start;
	logic              rem_busy_q;
	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] quot, quot_q;
	logic              accept;
	logic              page_end;
	logic              rel;
	logic [ADDR_W-1:0] addr_in;
	sfcs_pkg::desc_t   d;
	logic              pu;

	assign req_stall = q_full || rem_busy_q;
	assign accept    = req_valid && !req_stall;
	assign addr_in   = flash_address[ADDR_W-1:0];
	assign bl_dec    = (bl_q != '0) ? bl_q - 25'd1 : '0;
	assign page_end  = (off_q == OFF_W'(PAGE_BYTES - 1));
	assign rel       = page_end || (bl_q <= 25'd1);

	// page index of the start address by reciprocal multiplication
	assign prod = PROD_W'(addr_in) * PROD_W'(RECIP);
	assign quot = ADDR_W'(prod >> (ADDR_W + OFF_W));

	always_comb begin
		d          = '0;
		d.dat      = data_byte;
		d.tail     = sfcs_pkg::TAIL_NONE;
		pu         = 1'b1;
		rem_start  = 1'b0;
		mode_n     = mode_q;
		cur_n      = cur_q;
		bl_n       = bl_q;
		poll_n     = poll_q;
		resume_n   = resume_q;
		off_n      = off_q;
		priority if (command == sfcs_pkg::CMD_REPLY) begin
			priority if (mode_q == M_READ) begin
				d.host_en = 1'b1;
				bl_n = bl_dec;
				if (bl_dec != '0) begin
					d.tail = sfcs_pkg::TAIL_DUMMY;
					d.dummy_rel = (bl_dec == 25'd1);
				end else begin
					d.tail = sfcs_pkg::TAIL_DONE;
					mode_n = M_IDLE;
				end
			end else if (mode_q == M_STAT) begin
				d.host_en = 1'b1;
				d.tail = sfcs_pkg::TAIL_DONE;
				mode_n = M_IDLE;
			end else if ((mode_q == M_PROG || mode_q == M_WAIT) && poll_q) begin
				priority if (data_byte[0]) begin
					d.tail = sfcs_pkg::TAIL_POLL;
				end else if (mode_q == M_PROG && resume_q) begin
					poll_n = 1'b0;
					resume_n = 1'b0;
					d.wren_en = 1'b1;
					d.op_en = 1'b1;
					d.op_val = sfcs_pkg::OP_PP;
					d.addr_en = 1'b1;
					d.addr = 24'(cur_q);
				end else begin
					poll_n = 1'b0;
					resume_n = 1'b0;
					mode_n = M_IDLE;
					d.tail = sfcs_pkg::TAIL_DONE;
				end
			end else begin
				pu = 1'b0;
			end
		end else if (command == sfcs_pkg::CMD_PDATA && mode_q == M_PROG && !poll_q) begin
			d.byte_en = 1'b1;
			d.byte_rel = rel;
			cur_n = cur_q + ADDR_W'(1);
			off_n = (page_end || cur_q == '1) ? '0 : off_q + OFF_W'(1);
			bl_n = bl_dec;
			if (rel) begin
				resume_n = (bl_dec != '0);
				poll_n = 1'b1;
				d.tail = sfcs_pkg::TAIL_POLL;
			end
		end else if (command > sfcs_pkg::CMD_REPLY || mode_q != M_IDLE
				|| command == sfcs_pkg::CMD_PDATA) begin
			d.tail = sfcs_pkg::TAIL_REFUSE;
		end else if (command == sfcs_pkg::CMD_READ) begin
			d.op_en = 1'b1;
			d.op_val = sfcs_pkg::OP_READ;
			d.addr_en = 1'b1;
			d.addr = 24'(addr_in);
			d.addr_rel = (byte_count == '0);
			if (byte_count == '0) begin
				d.tail = sfcs_pkg::TAIL_DONE;
			end else begin
				bl_n = byte_count;
				mode_n = M_READ;
				d.tail = sfcs_pkg::TAIL_DUMMY;
				d.dummy_rel = (byte_count == 25'd1);
			end
		end else if (command == sfcs_pkg::CMD_PSTART) begin
			if (byte_count == '0) begin
				d.tail = sfcs_pkg::TAIL_DONE;
			end else begin
				cur_n = addr_in;
				bl_n = byte_count;
				mode_n = M_PROG;
				poll_n = 1'b0;
				resume_n = 1'b0;
				rem_start = 1'b1;
				d.wren_en = 1'b1;
				d.op_en = 1'b1;
				d.op_val = sfcs_pkg::OP_PP;
				d.addr_en = 1'b1;
				d.addr = 24'(addr_in);
			end
		end else if (command == sfcs_pkg::CMD_SERASE || command == sfcs_pkg::CMD_BERASE) begin
			d.wren_en = 1'b1;
			d.op_en = 1'b1;
			d.op_val = (command == sfcs_pkg::CMD_SERASE) ? sfcs_pkg::OP_SE : sfcs_pkg::OP_BE;
			d.addr_en = 1'b1;
			d.addr = 24'(addr_in);
			d.addr_rel = 1'b1;
			d.tail = sfcs_pkg::TAIL_POLL;
			mode_n = M_WAIT;
			resume_n = 1'b0;
			poll_n = 1'b1;
		end else if (command == sfcs_pkg::CMD_CERASE) begin
			d.wren_en = 1'b1;
			d.op_en = 1'b1;
			d.op_val = sfcs_pkg::OP_CE;
			d.op_rel = 1'b1;
			d.tail = sfcs_pkg::TAIL_POLL;
			mode_n = M_WAIT;
			resume_n = 1'b0;
			poll_n = 1'b1;
		end else if (command == sfcs_pkg::CMD_WRSR) begin
			d.wren_en = 1'b1;
			d.op_en = 1'b1;
			d.op_val = sfcs_pkg::OP_WRSR;
			d.byte_en = 1'b1;
			d.byte_rel = 1'b1;
			d.tail = sfcs_pkg::TAIL_POLL;
			mode_n = M_WAIT;
			resume_n = 1'b0;
			poll_n = 1'b1;
		end else begin
			d.tail = sfcs_pkg::TAIL_POLL;
			mode_n = M_STAT;
		end
	end

	assign push      = accept && pu;
	assign push_desc = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			cur_q      <= '0;
			bl_q       <= '0;
			poll_q     <= 1'b0;
			resume_q   <= 1'b0;
			off_q      <= '0;
			rem_busy_q <= 1'b0;
			quot_q     <= '0;
		end else if (rem_busy_q) begin
			rem_busy_q <= 1'b0;
			off_q      <= OFF_W'(cur_q) - OFF_W'(quot_q * ADDR_W'(PAGE_BYTES));
		end else if (accept) begin
			mode_q   <= mode_n;
			cur_q    <= cur_n;
			bl_q     <= bl_n;
			poll_q   <= poll_n;
			resume_q <= resume_n;
			off_q    <= off_n;
			if (rem_start) begin
				rem_busy_q <= 1'b1;
				quot_q     <= quot;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sfcs_queue.sv
// descriptor queue between decoder and byte sequencer
`default_nettype none
module sfcs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfcs_pkg::desc_t  push_desc,
	output logic                  full,
	input  wire logic             pop,
	output logic                  pop_valid,
	output sfcs_pkg::desc_t       pop_desc
);

	localparam int DEPTH = sfcs_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	sfcs_pkg::desc_t mem_q [DEPTH];
	logic [PW:0]     wr_q, rd_q;

	assign full      = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
	assign pop_valid = (wr_q != rd_q);
	assign pop_desc  = mem_q[rd_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[PW-1:0]] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + (PW + 1)'(1);
			end
			if (pop && pop_valid) begin
				rd_q <= rd_q + (PW + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/sfcs_back.sv
// byte sequencer: expands descriptors into result transactions
`default_nettype none
module sfcs_back #(
	parameter int ADDRESS_BITS = sfcs_pkg::ADDRESS_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire sfcs_pkg::desc_t  q_desc,
	output logic                  q_pop,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output logic [1:0]            result_kind,
	output logic [7:0]            value,
	output logic                  release_select,
	output logic                  capture_reply,
	output logic                  last
);

	localparam int NAB      = (ADDRESS_BITS + 7) / 8;
	localparam int SL_HOST  = 0;
	localparam int SL_WREN  = 1;
	localparam int SL_OP    = 2;
	localparam int SL_ADDR  = 3;
	localparam int SL_BYTE  = SL_ADDR + NAB;
	localparam int SL_TAIL0 = SL_BYTE + 1;
	localparam int SL_TAIL1 = SL_BYTE + 2;
	localparam int NSLOT    = SL_BYTE + 3;
	localparam int SW       = $clog2(NSLOT);

	sfcs_pkg::desc_t  cur_q;
	logic [NSLOT-1:0] mask_q, load_mask, cur_bit, rest;
	logic [SW-1:0]    idx, aidx;
	logic [31:0]      addr32;
	logic [1:0]       b_kind;
	logic [7:0]       b_val;
	logic             b_rel, b_cap;
	logic             out_adv, emit, load;
	logic             valid_q;

	always_comb begin
		load_mask = '0;
		load_mask[SL_HOST]  = q_desc.host_en;
		load_mask[SL_WREN]  = q_desc.wren_en;
		load_mask[SL_OP]    = q_desc.op_en;
		for (int i = 0; i < NAB; i++) begin
			load_mask[SL_ADDR + i] = q_desc.addr_en;
		end
		load_mask[SL_BYTE]  = q_desc.byte_en;
		load_mask[SL_TAIL0] = (q_desc.tail != sfcs_pkg::TAIL_NONE);
		load_mask[SL_TAIL1] = (q_desc.tail == sfcs_pkg::TAIL_POLL);
	end

	always_comb begin
		idx = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = SW'(i);
			end
		end
	end

	assign cur_bit = mask_q & (~mask_q + NSLOT'(1));
	assign rest    = mask_q & ~cur_bit;
	assign addr32  = 32'(cur_q.addr);
	assign aidx    = SW'(SL_BYTE - 1) - idx;

	always_comb begin
		b_kind = sfcs_pkg::KIND_SPI;
		b_val  = '0;
		b_rel  = 1'b0;
		b_cap  = 1'b0;
		priority if (idx == SW'(SL_HOST)) begin
			b_kind = sfcs_pkg::KIND_HOST;
			b_val  = cur_q.dat;
		end else if (idx == SW'(SL_WREN)) begin
			b_val = sfcs_pkg::OP_WREN;
			b_rel = 1'b1;
		end else if (idx == SW'(SL_OP)) begin
			b_val = cur_q.op_val;
			b_rel = cur_q.op_rel;
		end else if (idx < SW'(SL_BYTE)) begin
			b_val = 8'(addr32 >> {aidx, 3'b000});
			b_rel = (aidx == '0) && cur_q.addr_rel;
		end else if (idx == SW'(SL_BYTE)) begin
			b_val = cur_q.dat;
			b_rel = cur_q.byte_rel;
		end else if (idx == SW'(SL_TAIL0)) begin
			unique case (cur_q.tail)
				sfcs_pkg::TAIL_DONE: begin
					b_kind = sfcs_pkg::KIND_DONE;
				end
				sfcs_pkg::TAIL_REFUSE: begin
					b_kind = sfcs_pkg::KIND_REFUSE;
				end
				sfcs_pkg::TAIL_DUMMY: begin
					b_val = sfcs_pkg::DUMMY;
					b_rel = cur_q.dummy_rel;
					b_cap = 1'b1;
				end
				default: begin
					b_val = sfcs_pkg::OP_RDSR;
				end
			endcase
		end else begin
			b_val = sfcs_pkg::DUMMY;
			b_rel = 1'b1;
			b_cap = 1'b1;
		end
	end

	assign out_adv   = !valid_q || !rsp_stall;
	assign emit      = (mask_q != '0) && out_adv;
	assign load      = (mask_q == '0) || (emit && rest == '0);
	assign q_pop     = load && q_valid;
	assign rsp_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mask_q  <= '0;
		end else begin
			if (out_adv) begin
				valid_q <= emit;
			end
			if (q_pop) begin
				mask_q <= load_mask;
			end else if (emit) begin
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (emit) begin
			result_kind    <= b_kind;
			value          <= b_val;
			release_select <= b_rel;
			capture_reply  <= b_cap;
			last           <= (rest == '0);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/spi_flash_command_sequencer_unit.sv
// top level of the spi flash command sequencer
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  command, flash_address, byte_count, data_byte
//  rsp      out        rsp_valid / rsp_stall  result_kind, value, release_select,
//                                             capture_reply, last
//
// a request is decoded and queued; the sequencer sends one result per cycle while results are
// queued and rsp_stall is low, and each request causes 0 to 7 results at the default address width
// a program start holds req_stall high for one cycle after it while the page offset of
// the start address is formed from a registered reciprocal-multiply quotient
// req_stall also rises when the descriptor queue is full; rsp_stall backs up into it
// reset clears mode, counters, queue and output valid
`default_nettype none
module spi_flash_command_sequencer_unit #(
	parameter int PAGE_BYTES   = sfcs_pkg::PAGE_BYTES_DEF,
	parameter int ADDRESS_BITS = sfcs_pkg::ADDRESS_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [3:0]  command,
	input  wire logic [23:0] flash_address,
	input  wire logic [24:0] byte_count,
	input  wire logic [7:0]  data_byte,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [1:0]       result_kind,
	output logic [7:0]       value,
	output logic             release_select,
	output logic             capture_reply,
	output logic             last
);

	logic            q_full, push, q_pop, q_valid;
	sfcs_pkg::desc_t push_desc, q_desc;

	sfcs_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.command       (command),
		.flash_address (flash_address),
		.byte_count    (byte_count),
		.data_byte     (data_byte),
		.q_full        (q_full),
		.push          (push),
		.push_desc     (push_desc)
	);

	sfcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_desc  (q_desc)
	);

	sfcs_back #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_desc         (q_desc),
		.q_pop          (q_pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.result_kind    (result_kind),
		.value          (value),
		.release_select (release_select),
		.capture_reply  (capture_reply),
		.last           (last)
	);

endmodule
`default_nettype wire
